// ----- rtl/cres_pkg.sv -----
// Shared types and constants for the color run end scanner.
`timescale 1ns / 1ps
package cres_pkg;

	localparam int unsigned LINE_MAX_DEF = 4096;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned POS_W        = 12;
	localparam int unsigned CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_BELOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_BELOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RED_ABOVE   = 2'd2;

	localparam logic [7:0] BLUE_BELOW_RST  = 8'd50;
	localparam logic [7:0] GREEN_BELOW_RST = 8'd50;
	localparam logic [7:0] RED_ABOVE_RST   = 8'd200;

	typedef struct packed {
		logic [7:0] blue_level;
		logic [7:0] green_level;
		logic [7:0] red_level;
		logic       line_last;
	} pix_t;

	typedef struct packed {
		logic [POS_W-1:0] line_number;
		logic             found_two;
		logic [POS_W-1:0] first_end;
		logic [POS_W-1:0] second_end;
	} res_t;

	// classified pixel handed from front to back
	typedef struct packed {
		logic marked;
		logic last;
	} qent_t;

endpackage

// ----- rtl/cres_front.sv -----
// Front end: threshold registers and per-pixel marker classification.
`timescale 1ns / 1ps
module cres_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cres_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	input  cres_pkg::pix_t                 pix,
	output cres_pkg::qent_t                ent
);
	import cres_pkg::*;

	logic [7:0] blue_below_q;
	logic [7:0] green_below_q;
	logic [7:0] red_above_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blue_below_q  <= BLUE_BELOW_RST;
			green_below_q <= GREEN_BELOW_RST;
			red_above_q   <= RED_ABOVE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BLUE_BELOW:  blue_below_q  <= cfg_data;
				CFG_GREEN_BELOW: green_below_q <= cfg_data;
				CFG_RED_ABOVE:   red_above_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// last pixel of a line is never marked
	always_comb begin
		ent.last   = pix.line_last;
		ent.marked = (pix.blue_level < blue_below_q) && (pix.green_level < green_below_q)
			&& (pix.red_level > red_above_q) && !pix.line_last;
	end

endmodule

// ----- rtl/cres_queue.sv -----
// Short queue of classified pixels between front and back.
`timescale 1ns / 1ps
module cres_queue #(
	parameter int unsigned DEPTH = cres_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cres_pkg::qent_t wr_ent,
	output logic            full,
	input  logic            pop,
	output cres_pkg::qent_t rd_ent,
	output logic            not_empty
);
	import cres_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	qent_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full      = (count_q == (AW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_ent    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/cres_back.sv -----
// Back end: run tracking, end capture and the result register.
`timescale 1ns / 1ps
module cres_back #(
	parameter int unsigned LINE_MAX = cres_pkg::LINE_MAX_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  cres_pkg::qent_t q_ent,
	output logic            q_pop,
	output logic            res_valid,
	input  logic            res_stall,
	output cres_pkg::res_t  res
);
	import cres_pkg::*;

	localparam int unsigned PW = $clog2(LINE_MAX);

	logic                 in_run_q;
	logic [1:0]           runs_seen_q;
	logic [PW-1:0]        pos_q;
	logic [PW-1:0]        first_q;
	logic [PW-1:0]        second_q;
	logic [POS_W-1:0]     line_count_q;
	logic                 out_valid_q;
	res_t                 out_q;

	logic                 in_run_d;
	logic [1:0]           runs_seen_d;
	logic [PW-1:0]        first_d;
	logic [PW-1:0]        second_d;
	logic [POS_W-1:0]     first_view;
	logic [POS_W-1:0]     second_view;

	// hold off only while a finished result is blocked
	assign q_pop     = q_not_empty && (!out_valid_q || !res_stall);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		in_run_d    = in_run_q;
		runs_seen_d = runs_seen_q;
		first_d     = first_q;
		second_d    = second_q;
		if (q_ent.marked) begin
			in_run_d = 1'b1;
		end else if (in_run_q) begin
			in_run_d = 1'b0;
			if (runs_seen_q == 2'd0) begin
				first_d     = pos_q;
				runs_seen_d = 2'd1;
			end else if (runs_seen_q == 2'd1) begin
				second_d    = pos_q;
				runs_seen_d = 2'd2;
			end
		end
	end

	generate
		if (PW >= POS_W) begin : g_trunc
			assign first_view  = first_d[POS_W-1:0];
			assign second_view = second_d[POS_W-1:0];
		end else begin : g_ext
			assign first_view  = {{(POS_W-PW){1'b0}}, first_d};
			assign second_view = {{(POS_W-PW){1'b0}}, second_d};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (q_pop && q_ent.last) begin
			out_q.line_number <= line_count_q;
			out_q.found_two   <= (runs_seen_d == 2'd2);
			out_q.first_end   <= first_view;
			out_q.second_end  <= second_view;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q     <= 1'b0;
			runs_seen_q  <= '0;
			pos_q        <= '0;
			first_q      <= '0;
			second_q     <= '0;
			line_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop && q_ent.last) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (q_ent.last) begin
					in_run_q     <= 1'b0;
					runs_seen_q  <= '0;
					pos_q        <= '0;
					first_q      <= '0;
					second_q     <= '0;
					line_count_q <= line_count_q + 1'b1;
				end else begin
					in_run_q    <= in_run_d;
					runs_seen_q <= runs_seen_d;
					first_q     <= first_d;
					second_q    <= second_d;
					// position saturates on overlong lines
					if (pos_q != PW'(LINE_MAX-1)) begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

// ----- rtl/color_run_end_scanner_core.sv -----
// Color run end scanner: top level joining front, queue and back.
// Usage:
//   pix channel (pix_valid/pix_stall, payload pix) takes one pixel per request;
//   pix.line_last marks the final pixel of a line. Each pixel is compared with
//   the three thresholds and its marker class enters a two-entry queue.
//   res channel (res_valid/res_stall, payload res) gives one request per line:
//   line index, found-two flag and the end positions of the first two runs.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes thresholds;
//   cfg_ready is always high. Index 0 blue, 1 green, 2 red; index 3 ignored.
// Timing:
//   One pixel per cycle sustained while no result is blocked. A line's result
//   is registered when the back end pops its last pixel from the queue, so
//   res_valid rises once that pixel has passed the queue and the result register.
//   When res_stall holds, the back end stops only while a result waits; the
//   queue then fills and pix_stall rises after at most two more pixels.
// Reset:
//   arst_n clears the queue, run state, line counter and result valid, and
//   loads thresholds of 50 (blue), 50 (green) and 200 (red).
`timescale 1ns / 1ps
module color_run_end_scanner_core #(
	parameter int unsigned LINE_MAX = cres_pkg::LINE_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  cres_pkg::pix_t                 pix,
	output logic                           res_valid,
	input  logic                           res_stall,
	output cres_pkg::res_t                 res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cres_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);
	import cres_pkg::*;

	qent_t front_ent;
	qent_t back_ent;
	logic  q_full;
	logic  q_not_empty;
	logic  q_pop;
	logic  q_push;

	assign pix_stall = q_full;
	assign q_push    = pix_valid && !q_full;

	cres_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.ent       (front_ent)
	);

	cres_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_ent    (front_ent),
		.full      (q_full),
		.pop       (q_pop),
		.rd_ent    (back_ent),
		.not_empty (q_not_empty)
	);

	cres_back #(
		.LINE_MAX (LINE_MAX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_ent       (back_ent),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

endmodule
